// ===== src/mqsfl_pkg.sv =====
// ============================================================================
// mqsfl_pkg
// Types and constants shared by the multi-queue shared free list block.
// ============================================================================
package mqsfl_pkg;

    localparam int NumQueues   = 16;
    localparam int PoolEntries = 256;
    localparam int DataWidth   = 32;
    localparam int QselW       = 4;
    localparam int PtrW        = 8;
    localparam int CntW        = 9;
    localparam int QiuW        = 5;
    localparam int CfgIdxW     = 8;
    localparam int CfgDataW    = 16;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_ENQ   = 3'd0;
    localparam t_opcode OP_DEQ   = 3'd1;
    localparam t_opcode OP_RST   = 3'd2;
    localparam t_opcode OP_ALL   = 3'd3;
    localparam t_opcode OP_PEEK  = 3'd4;
    localparam t_opcode OP_CHECK = 3'd5;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_QUEUE_OOR  = 3'd1;
    localparam t_status ST_POOL_EMPTY = 3'd2;
    localparam t_status ST_QUEUE_EMPTY = 3'd3;
    localparam t_status ST_INDEX_OOR  = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_QUEUES  = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_ENTRIES = 8'd1;

    typedef struct packed {
        t_opcode               opcode;
        logic [QselW-1:0]      queue_select;
        logic [DataWidth-1:0]  entry_data;
        logic [PtrW-1:0]       peek_index;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [DataWidth-1:0]  read_data;
        logic                  all_nonnull;
        logic [CntW-1:0]       queue_length;
        logic [CntW-1:0]       free_count;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DECODE,
        CMD_ENQ,
        CMD_DEQ,
        CMD_SPLICE,
        CMD_ALL,
        CMD_WALK,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic load;
        t_cmd cmd;
    } t_ctrl_cmd;

    typedef struct packed {
        t_status pre_status;
        t_opcode op;
        logic    no_queues;
        logic    iter_last;
        logic    walk_done;
        logic    check_fail;
        logic    out_busy;
    } t_dp_status;

endpackage

// ===== src/mqsfl_ctrl.sv =====
// ============================================================================
// mqsfl_ctrl
// Sequencer: steps one operation at a time through the datapath.
// ============================================================================
module mqsfl_ctrl import mqsfl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_ENQ    = 8'b0000_0100,
        S_DEQ    = 8'b0000_1000,
        S_SPLICE = 8'b0001_0000,
        S_ALL    = 8'b0010_0000,
        S_WALK   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.cmd  = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.cmd = CMD_DECODE;
                if (i_sts.op == OP_ALL) begin
                    n_state = i_sts.no_queues ? S_DONE : S_ALL;
                end else if (i_sts.pre_status != ST_OK) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.op) inside
                        OP_ENQ:                 n_state = S_ENQ;
                        OP_DEQ:                 n_state = S_DEQ;
                        OP_RST:                 n_state = S_SPLICE;
                        OP_PEEK, OP_CHECK:      n_state = S_WALK;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_ENQ: begin
                o_cmd.cmd = CMD_ENQ;
                n_state   = S_DONE;
            end
            S_DEQ: begin
                o_cmd.cmd = CMD_DEQ;
                n_state   = S_DONE;
            end
            S_SPLICE: begin
                o_cmd.cmd = CMD_SPLICE;
                n_state   = S_DONE;
            end
            S_ALL: begin
                o_cmd.cmd = CMD_ALL;
                if (i_sts.iter_last) begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.cmd = CMD_WALK;
                if (i_sts.walk_done || i_sts.check_fail) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.cmd = CMD_FINISH;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mqsfl_dpath.sv =====
// ============================================================================
// mqsfl_dpath
// Link and payload memories, queue tables, free list registers, result register.
// ============================================================================
module mqsfl_dpath import mqsfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_in_item            i_in_data,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_sts,
    input  logic                i_cfg_valid,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    // Memories and their registered read port.
    logic [PtrW-1:0]      r_next_mem [PoolEntries];
    logic [DataWidth-1:0] r_pay_mem  [PoolEntries];
    logic [PoolEntries-1:0] r_next_vld;
    logic [PtrW-1:0]      r_rd_addr;
    logic [PtrW-1:0]      r_rd_next;
    logic                 r_rd_vld;
    logic [DataWidth-1:0] r_rd_pay;

    // Queue tables and free list.
    logic [PtrW-1:0] r_qhead [NumQueues];
    logic [PtrW-1:0] r_qtail [NumQueues];
    logic [CntW-1:0] r_qcnt  [NumQueues];
    logic [PtrW-1:0] r_free_head;
    logic [PtrW-1:0] r_free_tail;
    logic [CntW-1:0] r_free_total;
    logic [QiuW-1:0] r_qiu;
    logic [CntW-1:0] r_eiu;

    // Current operation.
    t_opcode              r_op;
    logic [QselW-1:0]     r_q;
    logic [DataWidth-1:0] r_data;
    logic [PtrW-1:0]      r_idx;
    logic [CntW-1:0]      r_cnt;
    logic [QselW-1:0]     r_iter;
    t_status              r_status;
    logic [DataWidth-1:0] r_rd;
    logic                 r_nonnull;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic            inrange;
    t_status         pre_status;
    logic [PtrW-1:0] rd_addr;
    logic [CntW-1:0] next_inc;
    logic [PtrW-1:0] next_eff;
    logic [QselW-1:0] sq;
    logic            nxt_we;
    logic [PtrW-1:0] nxt_wa;
    logic [PtrW-1:0] nxt_wd;
    logic            cfg_init;
    logic [QiuW-1:0] cfg_qiu;
    logic [CntW-1:0] cfg_eiu;
    logic [CntW-1:0] qcnt_dec;

    assign inrange  = {1'b0, r_q} < r_qiu;
    assign qcnt_dec = r_qcnt[r_q] - 1'b1;

    // An entry whose link was never written still holds its initial chain link.
    assign next_inc = {1'b0, r_rd_addr} + 1'b1;
    assign next_eff = r_rd_vld ? r_rd_next :
                      ((next_inc < r_eiu) ? next_inc[PtrW-1:0] : '0);

    always_comb begin
        pre_status = ST_OK;
        if (r_op != OP_ALL && r_op <= OP_CHECK && !inrange) begin
            pre_status = ST_QUEUE_OOR;
        end else begin
            case (r_op)
                OP_ENQ:  if (r_free_total == '0) pre_status = ST_POOL_EMPTY;
                OP_DEQ:  if (r_qcnt[r_q] == '0) pre_status = ST_QUEUE_EMPTY;
                OP_PEEK: if ({1'b0, r_idx} >= r_qcnt[r_q]) pre_status = ST_INDEX_OOR;
                default: pre_status = ST_OK;
            endcase
        end
    end

    assign o_sts.pre_status = pre_status;
    assign o_sts.op         = r_op;
    assign o_sts.no_queues  = (r_qiu == '0);
    assign o_sts.iter_last  = ({1'b0, r_iter} + 1'b1) == r_qiu;
    assign o_sts.walk_done  = (r_cnt == '0);
    assign o_sts.check_fail = (r_op == OP_CHECK) && (r_rd_pay == '0);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    always_comb begin
        rd_addr = '0;
        if (i_cmd.cmd == CMD_DECODE) begin
            rd_addr = (r_op == OP_ENQ) ? r_free_head : r_qhead[r_q];
        end else if (i_cmd.cmd == CMD_WALK) begin
            rd_addr = next_eff;
        end
    end

    assign sq = (i_cmd.cmd == CMD_ALL) ? r_iter : r_q;

    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = '0;
        nxt_wd = '0;
        case (i_cmd.cmd)
            CMD_ENQ: begin
                nxt_we = (r_qcnt[r_q] != '0);
                nxt_wa = r_qtail[r_q];
                nxt_wd = r_free_head;
            end
            CMD_DEQ: begin
                nxt_we = (r_free_total != '0);
                nxt_wa = r_free_tail;
                nxt_wd = r_qhead[r_q];
            end
            CMD_SPLICE, CMD_ALL: begin
                nxt_we = (r_qcnt[sq] != '0) && (r_free_total != '0);
                nxt_wa = r_free_tail;
                nxt_wd = r_qhead[sq];
            end
            default: begin
                nxt_we = 1'b0;
            end
        endcase
    end

    // Configuration: any write to a known register rebuilds the structure.
    assign cfg_init = i_cfg_valid && (i_cfg_index == CFG_QUEUES || i_cfg_index == CFG_ENTRIES);
    always_comb begin
        cfg_qiu = r_qiu;
        cfg_eiu = r_eiu;
        if (i_cfg_index == CFG_QUEUES) begin
            cfg_qiu = (i_cfg_data[QiuW-1:0] > QiuW'(NumQueues)) ? QiuW'(NumQueues)
                                                                : i_cfg_data[QiuW-1:0];
        end else begin
            cfg_eiu = (i_cfg_data[CntW-1:0] > CntW'(PoolEntries)) ? CntW'(PoolEntries)
                                                                  : i_cfg_data[CntW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        r_rd_next <= r_next_mem[rd_addr];
        r_rd_pay  <= r_pay_mem[rd_addr];
        if (nxt_we) begin
            r_next_mem[nxt_wa] <= nxt_wd;
        end
        if (i_cmd.cmd == CMD_ENQ) begin
            r_pay_mem[r_free_head] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_init) begin
            r_rd_vld   <= 1'b0;
            r_next_vld <= '0;
        end else begin
            r_rd_vld <= r_next_vld[rd_addr];
            if (nxt_we) begin
                r_next_vld[nxt_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qiu        <= QiuW'(NumQueues);
            r_eiu        <= CntW'(PoolEntries);
            r_free_head  <= '0;
            r_free_tail  <= PtrW'(PoolEntries - 1);
            r_free_total <= CntW'(PoolEntries);
            for (int i = 0; i < NumQueues; i++) begin
                r_qhead[i] <= '0;
                r_qtail[i] <= '0;
                r_qcnt[i]  <= '0;
            end
        end else if (cfg_init) begin
            r_qiu        <= cfg_qiu;
            r_eiu        <= cfg_eiu;
            r_free_head  <= '0;
            r_free_tail  <= (cfg_eiu != '0) ? PtrW'(cfg_eiu - 1'b1) : '0;
            r_free_total <= cfg_eiu;
            for (int i = 0; i < NumQueues; i++) begin
                r_qhead[i] <= '0;
                r_qtail[i] <= '0;
                r_qcnt[i]  <= '0;
            end
        end else begin
            case (i_cmd.cmd)
                CMD_ENQ: begin
                    r_free_head  <= next_eff;
                    r_free_total <= r_free_total - 1'b1;
                    if (r_qcnt[r_q] == '0) begin
                        r_qhead[r_q] <= r_free_head;
                    end
                    r_qtail[r_q] <= r_free_head;
                    r_qcnt[r_q]  <= r_qcnt[r_q] + 1'b1;
                end
                CMD_DEQ: begin
                    r_qcnt[r_q] <= qcnt_dec;
                    if (qcnt_dec == '0) begin
                        r_qhead[r_q] <= '0;
                        r_qtail[r_q] <= '0;
                    end else begin
                        r_qhead[r_q] <= next_eff;
                    end
                    if (r_free_total == '0) begin
                        r_free_head <= r_qhead[r_q];
                    end
                    r_free_tail  <= r_qhead[r_q];
                    r_free_total <= r_free_total + 1'b1;
                end
                CMD_SPLICE, CMD_ALL: begin
                    if (r_qcnt[sq] != '0) begin
                        if (r_free_total == '0) begin
                            r_free_head <= r_qhead[sq];
                        end
                        r_free_tail  <= r_qtail[sq];
                        r_free_total <= r_free_total + r_qcnt[sq];
                        r_qhead[sq]  <= '0;
                        r_qtail[sq]  <= '0;
                        r_qcnt[sq]   <= '0;
                    end
                end
                default: begin
                    r_free_total <= r_free_total;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_data.opcode;
            r_q    <= i_in_data.queue_select;
            r_data <= i_in_data.entry_data;
            r_idx  <= i_in_data.peek_index;
        end
        case (i_cmd.cmd)
            CMD_DECODE: begin
                r_status  <= pre_status;
                r_rd      <= '0;
                r_nonnull <= (r_op == OP_CHECK) && inrange;
                r_cnt     <= (r_op == OP_PEEK) ? {1'b0, r_idx} : r_qcnt[r_q];
                r_iter    <= '0;
            end
            CMD_DEQ: begin
                r_rd <= r_rd_pay;
            end
            CMD_ALL: begin
                r_iter <= r_iter + 1'b1;
            end
            CMD_WALK: begin
                if (r_cnt == '0) begin
                    if (r_op == OP_PEEK) begin
                        r_rd <= r_rd_pay;
                    end
                end else if (r_op == OP_CHECK && r_rd_pay == '0) begin
                    r_nonnull <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            CMD_FINISH: begin
                r_out.status       <= r_status;
                r_out.read_data    <= r_rd;
                r_out.all_nonnull  <= r_nonnull;
                r_out.queue_length <= inrange ? r_qcnt[r_q] : '0;
                r_out.free_count   <= r_free_total;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.cmd == CMD_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= r_eiu)
        else $error("free list holds more entries than the pool in use");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cmd == CMD_ENQ && !cfg_init) |=>
            r_qcnt[$past(r_q)] == $past(r_qcnt[r_q]) + 1'b1)
        else $error("enqueue did not lengthen the queue");

    a_empty_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt[r_q] == '0) |-> (r_qhead[r_q] == '0 && r_qtail[r_q] == '0))
        else $error("empty queue keeps stale head or tail");
`endif

endmodule

// ===== src/multi_queue_shared_free_list.sv =====
// ============================================================================
// multi_queue_shared_free_list
// Sixteen FIFO queues over one pool of 256 linked entries with a FIFO free list.
// ============================================================================
// Usage. Items arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_data) and each produces exactly one result on the output channel
// (o_out_valid / i_out_ready, payload o_out_data). A transfer happens at a
// rising edge with valid and ready both high. The configuration channel
// (i_cfg_valid / o_cfg_ready) is always ready; a write to either register
// rebuilds the whole structure and must only be made while the block is idle.
// Timing. One item is in work at a time. After its input transfer the item is
// decoded; enqueue, dequeue and a queue reset then take one step on the tables;
// reset-all steps over the queues in use, one queue per step; peek of position
// n and check of a queue walk the link chain one entry per step, a check
// stopping at the first null entry; a failed operation or an unused opcode
// goes straight to its result. The link memory read port, one access per
// cycle, paces the walk. The next input is taken in the cycle after the result is loaded.
// Stall. The result sits in an output register, so a new item is accepted
// while an earlier result still waits; a further result waits in the
// sequencer until the receiver takes the previous one.
// Reset. Synchronous active-low reset restores 16 queues and 256 entries,
// all queues empty and the whole pool chained on the free list; link state
// is cleared at once through per-entry valid bits, with no clearing pass.
// ============================================================================
module multi_queue_shared_free_list import mqsfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    // Configuration writes never stall.
    assign o_cfg_ready = 1'b1;

    // The sequencer owns the input handshake and decides each step.
    mqsfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds every store and the result register.
    mqsfl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/mqsfl_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mqsfl_checker
// Watches the command and result channels of the multi-queue block, keeps a
// shadow copy of the linked pool, predicts every result and compares it.
// ============================================================================
module mqsfl_checker import mqsfl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_item            i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_item           i_out_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    logic [PtrW-1:0]      link_next [PoolEntries];
    logic [DataWidth-1:0] link_word [PoolEntries];
    logic [PtrW-1:0]      q_head [NumQueues];
    logic [PtrW-1:0]      q_tail [NumQueues];
    int                   q_len [NumQueues];
    logic [PtrW-1:0]      fl_head, fl_tail;
    int                   fl_len;
    int                   active_queues, active_entries;
    t_out_item            expected_results [$];

    function automatic void pool_rebuild();
        for (int i = 0; i < NumQueues; i++) begin
            q_head[i] = '0;
            q_tail[i] = '0;
            q_len[i] = 0;
        end
        for (int i = 0; i < PoolEntries; i++) begin
            link_next[i] = (i + 1 < active_entries) ? PtrW'(i + 1) : '0;
        end
        fl_head = '0;
        fl_tail = active_entries != 0 ? PtrW'(active_entries - 1) : '0;
        fl_len = active_entries;
    endfunction

    function automatic void free_push(logic [PtrW-1:0] first, logic [PtrW-1:0] last, int n);
        if (fl_len != 0) begin
            link_next[fl_tail] = first;
        end else begin
            fl_head = first;
        end
        fl_tail = last;
        fl_len += n;
    endfunction

    function automatic void queue_release(int q);
        if (q_len[q] != 0) begin
            free_push(q_head[q], q_tail[q], q_len[q]);
            q_head[q] = '0;
            q_tail[q] = '0;
            q_len[q] = 0;
        end
    endfunction

    function automatic t_out_item predict_result(t_in_item cmd);
        t_out_item        r;
        int               q;
        logic             ok_sel;
        logic [PtrW-1:0]  e;
        r = '0;
        q = int'(cmd.queue_select);
        ok_sel = q < active_queues;
        if (cmd.opcode == OP_ALL) begin
            for (int i = 0; i < active_queues; i++) queue_release(i);
        end else if (cmd.opcode <= OP_CHECK && !ok_sel) begin
            r.status = ST_QUEUE_OOR;
        end else begin
            case (cmd.opcode)
                OP_ENQ: begin
                    if (fl_len == 0) begin
                        r.status = ST_POOL_EMPTY;
                    end else begin
                        e = fl_head;
                        fl_head = link_next[e];
                        fl_len--;
                        link_word[e] = cmd.entry_data;
                        if (q_len[q] != 0) link_next[q_tail[q]] = e;
                        else q_head[q] = e;
                        q_tail[q] = e;
                        q_len[q]++;
                    end
                end
                OP_DEQ: begin
                    if (q_len[q] == 0) begin
                        r.status = ST_QUEUE_EMPTY;
                    end else begin
                        e = q_head[q];
                        r.read_data = link_word[e];
                        q_head[q] = link_next[e];
                        q_len[q]--;
                        if (q_len[q] == 0) begin
                            q_head[q] = '0;
                            q_tail[q] = '0;
                        end
                        free_push(e, e, 1);
                    end
                end
                OP_RST: queue_release(q);
                OP_PEEK: begin
                    if (int'(cmd.peek_index) >= q_len[q]) begin
                        r.status = ST_INDEX_OOR;
                    end else begin
                        e = q_head[q];
                        for (int i = 0; i < int'(cmd.peek_index); i++) e = link_next[e];
                        r.read_data = link_word[e];
                    end
                end
                OP_CHECK: begin
                    r.all_nonnull = 1'b1;
                    e = q_head[q];
                    for (int i = 0; i < q_len[q]; i++) begin
                        if (link_word[e] == '0) begin
                            r.all_nonnull = 1'b0;
                            break;
                        end
                        e = link_next[e];
                    end
                end
                default: ;
            endcase
        end
        r.queue_length = ok_sel ? CntW'(q_len[q]) : '0;
        r.free_count = CntW'(fl_len);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            active_queues = NumQueues;
            active_entries = PoolEntries;
            pool_rebuild();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_QUEUES) begin
                    active_queues = int'(i_cfg_data[QiuW-1:0]);
                    if (active_queues > NumQueues) active_queues = NumQueues;
                    pool_rebuild();
                end else if (i_cfg_index == CFG_ENTRIES) begin
                    active_entries = int'(i_cfg_data[CntW-1:0]);
                    if (active_entries > PoolEntries) active_entries = PoolEntries;
                    pool_rebuild();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("Unexpected result %p", i_out_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_out_data) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("Mismatch: expected %p, got %p", exp_r, i_out_data);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(predict_result(i_in_data));
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives command items and register writes into the multi-queue block and
// gives the verdict from the checker's failure count.
// ============================================================================
module testbench;
    import mqsfl_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_item            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    int                  errors, pending;
    int                  cycle_count = 0;
    // Set while the receiver is told to hold off for a long stretch.
    logic                hold_results = 1'b0;

    // The clock period is 4 ns.
    always #2 i_clk = ~i_clk;

    multi_queue_shared_free_list dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mqsfl_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // A generous cycle limit: every item can spend time in a walk and in receiver
    // stall, so the limit sits far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver waits a random number of cycles before each transfer; in
    // the long hold-off it stays low for a counted stretch.
    initial begin : receiver
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_results = 1'b0;
            end
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
        end
    end

    // One transfer on the command channel, after a random gap, or none when no_gap is set.
    // Valid is dropped only when a gap follows, so back-to-back items keep it high.
    task automatic send_command(t_opcode op, int q, logic [31:0] word, int idx, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data <= '{opcode: op, queue_select: QselW'(q), entry_data: word,
                     peek_index: PtrW'(idx)};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every result has come back, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Register writes are made only while the block is idle.
    task automatic write_register(logic [CfgIdxW-1:0] idx, int value);
        drain();
        cfg_index <= idx;
        cfg_data <= CfgDataW'(value);
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random data: mostly full words, sometimes zero so that check sees nulls.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random phase: mainly enqueue and dequeue over the queues in use, with
    // walks, resets and the odd out-of-range or unused opcode.
    task automatic random_phase(int count, int qmax, bit burst);
        int r;
        t_opcode op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) op = OP_ENQ;
            else if (r < 75) op = OP_DEQ;
            else if (r < 85) op = OP_PEEK;
            else if (r < 91) op = OP_CHECK;
            else if (r < 95) op = OP_RST;
            else if (r < 97) op = OP_ALL;
            else op = t_opcode'($urandom_range(0, 7));
            send_command(op, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, qmax),
                         pick_word(),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 6),
                         burst);
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every opcode and the boundary cases.
        send_command(OP_DEQ, 0, '0, 0, 1'b0);          // empty queue
        send_command(OP_CHECK, 0, '0, 0, 1'b0);        // check of an empty queue
        send_command(OP_ENQ, 0, '1, 0, 1'b0);
        send_command(OP_ENQ, 0, '0, 0, 1'b0);          // null data
        send_command(OP_ENQ, 15, 32'h8000_0001, 0, 1'b0);
        send_command(OP_PEEK, 0, '0, 1, 1'b0);
        send_command(OP_PEEK, 0, '0, 255, 1'b0);       // beyond length
        send_command(OP_CHECK, 0, '0, 0, 1'b0);
        send_command(OP_DEQ, 0, '0, 0, 1'b0);
        send_command(OP_RST, 0, '0, 0, 1'b0);
        send_command(OP_RST, 3, '0, 0, 1'b0);          // reset of an empty queue
        send_command(3'd6, 15, '0, 0, 1'b0);
        send_command(3'd7, 1, '0, 0, 1'b0);
        send_command(OP_ALL, 15, '0, 0, 1'b0);

        // Small configuration: two queues, four entries, pool exhaustion.
        write_register(CFG_QUEUES, 2);
        write_register(CFG_ENTRIES, 4);
        for (int i = 0; i < 5; i++) send_command(OP_ENQ, i & 1, 32'hA5A5_0000 + i, 0, 1'b0);
        send_command(OP_ENQ, 2, 32'h1, 0, 1'b0);       // select beyond queues in use
        random_phase(150, 1, 1'b0);

        // Extremes: no queues, then no entries.
        write_register(CFG_QUEUES, 0);
        send_command(OP_ENQ, 0, 32'h1, 0, 1'b0);
        send_command(OP_ALL, 0, '0, 0, 1'b0);
        write_register(CFG_QUEUES, 31);                // saturates to sixteen
        write_register(CFG_ENTRIES, 0);
        send_command(OP_ENQ, 5, 32'h1, 0, 1'b0);
        write_register(CFG_ENTRIES, 511);              // saturates to the full pool
        write_register(8'd2, 7);                       // ignored index

        random_phase(300, 15, 1'b0);

        // Long hold-off by the receiver while items keep arriving back to back.
        hold_results = 1'b1;
        random_phase(60, 3, 1'b1);
        drain();

        write_register(CFG_QUEUES, 1);
        write_register(CFG_ENTRIES, 256);
        random_phase(200, 0, 1'b0);

        write_register(CFG_QUEUES, 16);
        write_register(CFG_ENTRIES, 20);
        random_phase(250, 15, 1'b0);

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
